>>> rtl/vqdm_pkg.sv
// Package for the virtqueue descriptor manager.
// Holds the item and result types, operation and status codes and default sizes.
// No dependencies.
`default_nettype none

package vqdm_pkg;

  localparam int DEF_QUEUE_DEPTH  = 256;
  localparam int DEF_BUFFER_BYTES = 1600;
  localparam int HDR_BYTES        = 10;
  localparam logic [15:0] INDEX_LAST = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_POST     = 2'd0,
    MODE_COMPLETE = 2'd1,
    MODE_POLL     = 2'd2,
    MODE_SPARE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_DESC  = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_NOTHING  = 3'd3,
    ST_SHORT    = 3'd4,
    ST_BAD_ID   = 3'd5
  } status_t;

  localparam logic REG_QUEUE_SIZE = 1'b0;
  localparam logic REG_RECEIVE    = 1'b1;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] payload_len;
    logic [7:0]  used_id;
    logic [15:0] used_len;
    logic [15:0] max_len;
    logic [15:0] device_used_index;
  } vqdm_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  desc_index;
    logic [10:0] desc_length;
    logic        desc_writable;
    logic [7:0]  avail_slot;
    logic [15:0] avail_index_out;
    logic [7:0]  used_slot;
    logic [15:0] delivered_len;
    logic        pending;
    logic [8:0]  free_count_out;
  } vqdm_result_t;

endpackage

`default_nettype wire

>>> rtl/vqdm_link_ram.sv
// Free-list link memory: one write port, one registered read port.
// No dependencies.
`default_nettype none

module vqdm_link_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 9
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/vqdm_step.sv
// Single-item step logic: free-list pop/push, ring slots, length checks.
// Depends on vqdm_pkg.
`default_nettype none

module vqdm_step #(
  parameter int QUEUE_DEPTH  = vqdm_pkg::DEF_QUEUE_DEPTH,
  parameter int BUFFER_BYTES = vqdm_pkg::DEF_BUFFER_BYTES,
  parameter int IW = $clog2(QUEUE_DEPTH),
  parameter int LW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire vqdm_pkg::vqdm_item_t item,
  input  wire logic [LW-1:0]        size,
  input  wire logic                 receive,
  input  wire logic [LW-1:0]        head,
  input  wire logic [LW-1:0]        head_link,
  input  wire logic [LW-1:0]        free_count,
  input  wire logic [15:0]          avail_index,
  input  wire logic [IW-1:0]        avail_slot,
  input  wire logic [15:0]          last_used,
  input  wire logic [IW-1:0]        used_slot,
  output vqdm_pkg::vqdm_result_t    result,
  output logic [LW-1:0]             head_next,
  output logic [LW-1:0]             free_count_next,
  output logic [15:0]               avail_index_next,
  output logic [IW-1:0]             avail_slot_next,
  output logic [15:0]               last_used_next,
  output logic [IW-1:0]             used_slot_next,
  output logic                      wr_en,
  output logic [IW-1:0]             wr_addr,
  output logic [LW-1:0]             wr_data
);
  import vqdm_pkg::*;

  logic [16:0] tx_len;
  logic [15:0] strip_len;

  function automatic logic [IW-1:0] slot_step(input logic [IW-1:0] slot,
                                              input logic [15:0] index,
                                              input logic [LW-1:0] sz);
    logic [LW-1:0] inc;
    inc = LW'(slot) + LW'(1);
    if (index == INDEX_LAST || inc == sz) begin
      return '0;
    end
    return inc[IW-1:0];
  endfunction

  assign tx_len    = {1'b0, item.payload_len} + 17'(HDR_BYTES);
  assign strip_len = item.used_len - 16'(HDR_BYTES);

  always_comb begin
    result           = '0;
    result.status    = ST_OK;
    head_next        = head;
    free_count_next  = free_count;
    avail_index_next = avail_index;
    avail_slot_next  = avail_slot;
    last_used_next   = last_used;
    used_slot_next   = used_slot;
    wr_en            = 1'b0;
    wr_addr          = head[IW-1:0];
    wr_data          = '0;
    case (item.mode)
      MODE_POST: begin
        if (!receive && (item.payload_len == 16'd0 || tx_len > 17'(BUFFER_BYTES))) begin
          result.status = ST_BAD_LEN;
        end else if (free_count == '0 || head >= size) begin
          result.status = ST_NO_DESC;
        end else begin
          wr_en                = 1'b1;
          head_next            = head_link;
          free_count_next      = free_count - LW'(1);
          result.desc_index    = 8'(head);
          result.desc_length   = receive ? 11'(BUFFER_BYTES) : tx_len[10:0];
          result.desc_writable = receive;
          result.avail_slot    = 8'(avail_slot);
          avail_index_next     = avail_index + 16'd1;
          avail_slot_next      = slot_step(avail_slot, avail_index, size);
        end
      end
      MODE_COMPLETE: begin
        if (last_used == item.device_used_index) begin
          result.status = ST_NOTHING;
        end else if (item.max_len == 16'd0) begin
          result.status = ST_BAD_LEN;
        end else begin
          result.used_slot  = 8'(used_slot);
          last_used_next    = last_used + 16'd1;
          used_slot_next    = slot_step(used_slot, last_used, size);
          result.desc_index = item.used_id;
          if (16'(item.used_id) >= 16'(size) || free_count >= size) begin
            result.status = ST_BAD_ID;
          end else begin
            wr_en           = 1'b1;
            wr_addr         = IW'(item.used_id);
            wr_data         = head;
            head_next       = LW'(item.used_id);
            free_count_next = free_count + LW'(1);
            if (item.used_len <= 16'(HDR_BYTES)) begin
              result.status = ST_SHORT;
            end else begin
              result.delivered_len = (strip_len > item.max_len) ? item.max_len : strip_len;
            end
          end
        end
      end
      default: begin
        result.status = (last_used != item.device_used_index) ? ST_OK : ST_NOTHING;
      end
    endcase
    result.avail_index_out = avail_index_next;
    result.pending         = (last_used_next != item.device_used_index);
    result.free_count_out  = 9'(free_count_next);
  end

endmodule

`default_nettype wire

>>> rtl/virtqueue_descriptor_manager_unit.sv
// Top level of the virtqueue descriptor manager: input and result registers,
// queue state, link-memory clearing pass. Depends on vqdm_pkg, vqdm_step, vqdm_link_ram.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    mode payload_len used_id used_len max_len
//                                            device_used_index
//   out      source     out_valid/out_ready  status desc_index desc_length desc_writable
//                                            avail_slot avail_index_out used_slot
//                                            delivered_len pending free_count_out
//   cfg      sink       cfg_valid/cfg_ready  cfg_index cfg_data
//
// One item per cycle while out_ready is high and no clearing pass runs; item and result are registered.
// The link memory's one write port and registered read carry one pop or push a cycle.
// After reset and after every queue_size write, a clearing pass rewrites every link-memory entry;
// in_ready is low meanwhile, cfg is always ready.
// A result held by out_ready low stalls the step; one more item waits in the input register.
`default_nettype none

module virtqueue_descriptor_manager_unit #(
  parameter int QUEUE_DEPTH  = vqdm_pkg::DEF_QUEUE_DEPTH,
  parameter int BUFFER_BYTES = vqdm_pkg::DEF_BUFFER_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] payload_len,
  input  wire logic [7:0]  used_id,
  input  wire logic [15:0] used_len,
  input  wire logic [15:0] max_len,
  input  wire logic [15:0] device_used_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [7:0]       desc_index,
  output logic [10:0]      desc_length,
  output logic             desc_writable,
  output logic [7:0]       avail_slot,
  output logic [15:0]      avail_index_out,
  output logic [7:0]       used_slot,
  output logic [15:0]      delivered_len,
  output logic             pending,
  output logic [8:0]       free_count_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [8:0]  cfg_data
);
  import vqdm_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  logic          in_full;
  vqdm_item_t    item;
  vqdm_result_t  res;
  vqdm_result_t  res_next;

  logic [8:0]    queue_size;
  logic          receive;
  logic          clearing;
  logic [LW-1:0] clr_cnt;
  logic [LW-1:0] clr_inc;

  logic [LW-1:0] head;
  logic [LW-1:0] free_count;
  logic [15:0]   avail_index;
  logic [IW-1:0] avail_slot_q;
  logic [15:0]   last_used;
  logic [IW-1:0] used_slot_q;
  logic          link_byp;
  logic [LW-1:0] link_hold;

  logic [LW-1:0] size;
  logic [LW-1:0] head_link;
  logic [LW-1:0] ram_q;
  logic          fire;
  logic          cfg_fire;

  logic [LW-1:0] head_next;
  logic [LW-1:0] free_count_next;
  logic [15:0]   avail_index_next;
  logic [IW-1:0] avail_slot_next;
  logic [15:0]   last_used_next;
  logic [IW-1:0] used_slot_next;
  logic          step_wr_en;
  logic [IW-1:0] step_wr_addr;
  logic [LW-1:0] step_wr_data;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [LW-1:0] wr_data;
  logic [LW-1:0] rd_head;
  logic [IW-1:0] rd_addr;

  always_comb begin
    if (queue_size == 9'd0) begin
      size = LW'(1);
    end else if (32'(queue_size) > 32'(QUEUE_DEPTH)) begin
      size = LW'(QUEUE_DEPTH);
    end else begin
      size = LW'(queue_size);
    end
  end

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign fire      = in_full & (~out_valid | out_ready) & ~clearing;
  assign in_ready  = ~clearing & (~in_full | fire);
  assign head_link = link_byp ? link_hold : ram_q;
  assign clr_inc   = clr_cnt + LW'(1);

  vqdm_step #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .BUFFER_BYTES (BUFFER_BYTES),
    .IW           (IW),
    .LW           (LW)
  ) u_step (
    .item             (item),
    .size             (size),
    .receive          (receive),
    .head             (head),
    .head_link        (head_link),
    .free_count       (free_count),
    .avail_index      (avail_index),
    .avail_slot       (avail_slot_q),
    .last_used        (last_used),
    .used_slot        (used_slot_q),
    .result           (res_next),
    .head_next        (head_next),
    .free_count_next  (free_count_next),
    .avail_index_next (avail_index_next),
    .avail_slot_next  (avail_slot_next),
    .last_used_next   (last_used_next),
    .used_slot_next   (used_slot_next),
    .wr_en            (step_wr_en),
    .wr_addr          (step_wr_addr),
    .wr_data          (step_wr_data)
  );

  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt[IW-1:0];
      wr_data = (clr_inc < size) ? clr_inc : size;
      rd_head = '0;
    end else begin
      wr_en   = fire & step_wr_en;
      wr_addr = step_wr_addr;
      wr_data = step_wr_data;
      rd_head = fire ? head_next : head;
    end
  end

  assign rd_addr = rd_head[IW-1:0];

  vqdm_link_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (IW),
    .DW    (LW)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    link_byp  <= wr_en && (wr_addr == rd_addr);
    link_hold <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.mode              <= mode_t'(mode);
      item.payload_len       <= payload_len;
      item.used_id           <= used_id;
      item.used_len          <= used_len;
      item.max_len           <= max_len;
      item.device_used_index <= device_used_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_size <= 9'd256;
      receive    <= 1'b1;
      clearing   <= 1'b1;
      clr_cnt    <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_QUEUE_SIZE: begin
            queue_size <= cfg_data;
          end
          REG_RECEIVE: begin
            receive <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
      if (cfg_fire && cfg_index == REG_QUEUE_SIZE) begin
        clearing <= 1'b1;
        clr_cnt  <= '0;
      end else if (clearing) begin
        clr_cnt <= clr_inc;
        if (clr_cnt == LW'(QUEUE_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      free_count   <= '0;
      avail_index  <= '0;
      avail_slot_q <= '0;
      last_used    <= '0;
      used_slot_q  <= '0;
    end else if (clearing) begin
      head         <= '0;
      free_count   <= size;
      avail_index  <= '0;
      avail_slot_q <= '0;
      last_used    <= '0;
      used_slot_q  <= '0;
    end else if (fire) begin
      head         <= head_next;
      free_count   <= free_count_next;
      avail_index  <= avail_index_next;
      avail_slot_q <= avail_slot_next;
      last_used    <= last_used_next;
      used_slot_q  <= used_slot_next;
    end
  end

  assign status          = res.status;
  assign desc_index      = res.desc_index;
  assign desc_length     = res.desc_length;
  assign desc_writable   = res.desc_writable;
  assign avail_slot      = res.avail_slot;
  assign avail_index_out = res.avail_index_out;
  assign used_slot       = res.used_slot;
  assign delivered_len   = res.delivered_len;
  assign pending         = res.pending;
  assign free_count_out  = res.free_count_out;

endmodule

`default_nettype wire

>>> tb/virtqueue_descriptor_manager_unit_tb.sv
// Testbench for virtqueue_descriptor_manager_unit: a directed table, then random phases
// checked against an in-bench model of the free list, ring indices and result fields.
// Depends on vqdm_pkg and the unit itself.
`timescale 1ns / 1ps

module virtqueue_descriptor_manager_unit_tb;
  import vqdm_pkg::*;

  localparam int DEPTH = DEF_QUEUE_DEPTH;
  localparam int BUF = DEF_BUFFER_BYTES;
  localparam int HDR = HDR_BYTES;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] mode = '0;
  logic [15:0] payload_len = '0;
  logic [7:0] used_id = '0;
  logic [15:0] used_len = '0;
  logic [15:0] max_len = '0;
  logic [15:0] device_used_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [7:0] desc_index;
  logic [10:0] desc_length;
  logic desc_writable;
  logic [7:0] avail_slot;
  logic [15:0] avail_index_out;
  logic [7:0] used_slot;
  logic [15:0] delivered_len;
  logic pending;
  logic [8:0] free_count_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_QUEUE_SIZE;
  logic [8:0] cfg_data = '0;

  virtqueue_descriptor_manager_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // queue model
  logic [8:0] qsize;
  logic rx_mode;
  logic [8:0] nxt [DEPTH];
  logic [8:0] head;
  logic [8:0] nfree;
  logic [15:0] avail_ctr;
  logic [15:0] used_ctr;
  logic [7:0] in_flight [$];
  vqdm_result_t predicted_results [$];

  int mismatches = 0;
  bit calm = 1'b0;
  bit hold_request = 1'b0;

  typedef struct {
    bit is_cfg;
    logic cfg_idx;
    logic [8:0] cfg_val;
    vqdm_item_t item;
    bit typed;
    vqdm_result_t res;
  } row_t;

  row_t script [$];

  function automatic int eff_size();
    if (qsize == 0) return 1;
    if (qsize > DEPTH) return DEPTH;
    return int'(qsize);
  endfunction

  function automatic void rebuild_free_list();
    int s;
    s = eff_size();
    for (int i = 0; i < DEPTH; i++) nxt[i] = 9'((i + 1 < s) ? i + 1 : s);
    head = '0;
    nfree = 9'(s);
    avail_ctr = '0;
    used_ctr = '0;
    in_flight.delete();
  endfunction

  function automatic void set_reg(logic idx, logic [8:0] val);
    if (idx == REG_QUEUE_SIZE) begin
      qsize = val;
      rebuild_free_list();
    end else begin
      rx_mode = val[0];
    end
  endfunction

  function automatic vqdm_result_t queue_step(vqdm_item_t it);
    vqdm_result_t r;
    int s;
    int len;
    int dlen;
    logic [8:0] d;
    s = eff_size();
    r = '0;
    r.status = ST_OK;
    case (it.mode)
      MODE_POST: begin
        len = rx_mode ? BUF : int'(it.payload_len) + HDR;
        if (!rx_mode && (it.payload_len == 0 || len > BUF)) begin
          r.status = ST_BAD_LEN;
        end else if (nfree == 0 || int'(head) >= s) begin
          r.status = ST_NO_DESC;
        end else begin
          d = head;
          head = nxt[d];
          nxt[d] = '0;
          nfree = nfree - 9'd1;
          r.desc_index = d[7:0];
          r.desc_length = 11'(len);
          r.desc_writable = rx_mode;
          r.avail_slot = 8'(int'(avail_ctr) % s);
          avail_ctr = avail_ctr + 16'd1;
        end
      end
      MODE_COMPLETE: begin
        if (used_ctr == it.device_used_index) begin
          r.status = ST_NOTHING;
        end else if (it.max_len == 0) begin
          r.status = ST_BAD_LEN;
        end else begin
          r.used_slot = 8'(int'(used_ctr) % s);
          used_ctr = used_ctr + 16'd1;
          r.desc_index = it.used_id;
          if (int'(it.used_id) >= s || int'(nfree) >= s) begin
            r.status = ST_BAD_ID;
          end else begin
            nxt[it.used_id] = head;
            head = {1'b0, it.used_id};
            nfree = nfree + 9'd1;
            if (int'(it.used_len) <= HDR) begin
              r.status = ST_SHORT;
            end else begin
              dlen = int'(it.used_len) - HDR;
              r.delivered_len = (dlen > int'(it.max_len)) ? it.max_len : 16'(dlen);
            end
          end
        end
      end
      default: begin
        r.status = (used_ctr != it.device_used_index) ? ST_OK : ST_NOTHING;
      end
    endcase
    r.avail_index_out = avail_ctr;
    r.pending = (used_ctr != it.device_used_index);
    r.free_count_out = nfree;
    return r;
  endfunction

  function automatic vqdm_item_t op(mode_t m, int pl, int id, int ul, int ml, int dev);
    vqdm_item_t it;
    it.mode = m;
    it.payload_len = 16'(pl);
    it.used_id = 8'(id);
    it.used_len = 16'(ul);
    it.max_len = 16'(ml);
    it.device_used_index = 16'(dev);
    return it;
  endfunction

  function automatic vqdm_result_t outcome(status_t st, int di, int dl, bit w, int aslot,
                                           int aidx, int uslot, int dlen, bit pend, int fc);
    vqdm_result_t r;
    r.status = st;
    r.desc_index = 8'(di);
    r.desc_length = 11'(dl);
    r.desc_writable = w;
    r.avail_slot = 8'(aslot);
    r.avail_index_out = 16'(aidx);
    r.used_slot = 8'(uslot);
    r.delivered_len = 16'(dlen);
    r.pending = pend;
    r.free_count_out = 9'(fc);
    return r;
  endfunction

  function automatic void add_row(vqdm_item_t it, bit typed, vqdm_result_t res);
    row_t row;
    row.is_cfg = 1'b0;
    row.cfg_idx = REG_QUEUE_SIZE;
    row.cfg_val = '0;
    row.item = it;
    row.typed = typed;
    row.res = res;
    script.push_back(row);
  endfunction

  function automatic void add_cfg(logic idx, logic [8:0] val);
    row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    script.push_back(row);
  endfunction

  // well-formed posts and completions mostly, the rest noise
  function automatic vqdm_item_t random_item();
    vqdm_item_t it;
    int r;
    int k;
    it.mode = mode_t'($urandom_range(0, 3));
    it.payload_len = 16'($urandom);
    it.used_id = 8'($urandom);
    it.used_len = 16'($urandom);
    it.max_len = 16'($urandom);
    it.device_used_index = 16'($urandom);
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 99);
    if (r < 40) begin
      it.mode = MODE_POST;
      if (!rx_mode) begin
        if (k < 8) it.payload_len = '0;
        else if (k < 16) it.payload_len = 16'($urandom_range(BUF - HDR + 1, 65535));
        else if (k < 22) it.payload_len = 16'(BUF - HDR);
        else it.payload_len = 16'($urandom_range(1, BUF - HDR - 1));
      end
    end else if (r < 82 && in_flight.size() != 0) begin
      it.mode = MODE_COMPLETE;
      it.used_id = in_flight[$urandom_range(0, in_flight.size() - 1)];
      it.device_used_index = used_ctr + 16'($urandom_range(1, 4));
      if (k < 15) it.used_len = 16'($urandom_range(0, HDR));
      else if (k < 80) it.used_len = 16'($urandom_range(HDR + 1, BUF + HDR));
      k = $urandom_range(0, 99);
      if (k < 5) it.max_len = '0;
      else if (k < 25) it.max_len = 16'($urandom_range(1, 64));
      else it.max_len = 16'($urandom_range(1, 65535));
    end else if (r < 92) begin
      it.mode = MODE_POLL;
      if (k < 50) it.device_used_index = used_ctr;
    end
    return it;
  endfunction

  task automatic send_item(vqdm_item_t it, bit typed, vqdm_result_t typed_res);
    vqdm_result_t r;
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= it.mode;
    payload_len <= it.payload_len;
    used_id <= it.used_id;
    used_len <= it.used_len;
    max_len <= it.max_len;
    device_used_index <= it.device_used_index;
    do @(posedge clk); while (in_ready !== 1'b1);
    r = queue_step(it);
    predicted_results.push_back(typed ? typed_res : r);
    if (it.mode == MODE_POST && r.status == ST_OK) begin
      in_flight.push_back(r.desc_index);
    end else if (it.mode == MODE_COMPLETE && (r.status == ST_OK || r.status == ST_SHORT)) begin
      for (int i = 0; i < in_flight.size(); i++) begin
        if (in_flight[i] == it.used_id) begin
          in_flight.delete(i);
          break;
        end
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    set_reg(idx, val);
  endtask

  // stimulus
  initial begin
    logic [8:0] sz;
    logic rxv;
    qsize = 9'(DEPTH);
    rx_mode = 1'b1;
    rebuild_free_list();

    add_row(op(MODE_POLL, 0, 0, 0, 0, 0), 1, outcome(ST_NOTHING, 0, 0, 0, 0, 0, 0, 0, 0, 256));
    add_row(op(MODE_COMPLETE, 0, 0, 100, 100, 0), 1,
            outcome(ST_NOTHING, 0, 0, 0, 0, 0, 0, 0, 0, 256));
    add_row(op(MODE_POST, 65535, 0, 0, 0, 0), 1, outcome(ST_OK, 0, 1600, 1, 0, 1, 0, 0, 0, 255));
    add_row(op(MODE_POST, 0, 0, 0, 0, 0), 1, outcome(ST_OK, 1, 1600, 1, 1, 2, 0, 0, 0, 254));
    add_row(op(MODE_COMPLETE, 0, 0, 65535, 65535, 65535), 1,
            outcome(ST_OK, 0, 0, 0, 0, 2, 0, 65525, 1, 255));
    add_row(op(MODE_COMPLETE, 0, 255, 500, 0, 65535), 1,
            outcome(ST_BAD_LEN, 0, 0, 0, 0, 2, 0, 0, 1, 255));
    add_row(op(MODE_COMPLETE, 0, 1, 10, 1, 65535), 1,
            outcome(ST_SHORT, 1, 0, 0, 0, 2, 1, 0, 1, 256));
    add_row(op(MODE_COMPLETE, 0, 255, 500, 500, 65535), 1,
            outcome(ST_BAD_ID, 255, 0, 0, 0, 2, 2, 0, 1, 256));
    add_row(op(MODE_SPARE, 0, 0, 0, 0, 3), 1, outcome(ST_NOTHING, 0, 0, 0, 0, 2, 0, 0, 0, 256));
    add_row(op(MODE_POLL, 0, 0, 0, 0, 0), 1, outcome(ST_OK, 0, 0, 0, 0, 2, 0, 0, 1, 256));
    add_row(op(MODE_POST, 0, 0, 0, 0, 3), 0, '0);
    add_row(op(MODE_COMPLETE, 0, 1, 11, 1, 4), 0, '0);
    add_cfg(REG_RECEIVE, 9'd0);
    add_row(op(MODE_POST, 0, 0, 0, 0, 4), 1, outcome(ST_BAD_LEN, 0, 0, 0, 0, 3, 0, 0, 0, 256));
    add_row(op(MODE_POST, 1591, 0, 0, 0, 4), 1,
            outcome(ST_BAD_LEN, 0, 0, 0, 0, 3, 0, 0, 0, 256));
    add_row(op(MODE_POST, 65535, 0, 0, 0, 4), 1,
            outcome(ST_BAD_LEN, 0, 0, 0, 0, 3, 0, 0, 0, 256));
    add_row(op(MODE_POST, 1590, 0, 0, 0, 4), 0, '0);
    add_row(op(MODE_POST, 1, 0, 0, 0, 4), 0, '0);
    add_cfg(REG_QUEUE_SIZE, 9'd0);
    add_row(op(MODE_POST, 5, 0, 0, 0, 0), 0, '0);
    add_row(op(MODE_POST, 5, 0, 0, 0, 0), 1, outcome(ST_NO_DESC, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    add_row(op(MODE_COMPLETE, 0, 1, 50, 50, 1), 1,
            outcome(ST_BAD_ID, 1, 0, 0, 0, 1, 0, 0, 0, 0));
    add_row(op(MODE_COMPLETE, 0, 0, 0, 65535, 2), 0, '0);
    add_cfg(REG_QUEUE_SIZE, 9'h1FF);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain();
        write_reg(script[i].cfg_idx, script[i].cfg_val);
      end else begin
        send_item(script[i].item, script[i].typed, script[i].res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: sz = 9'd2;
        1: sz = 9'd4;
        2: sz = 9'd256;
        3: sz = 9'($urandom_range(3, 40));
        4: sz = 9'd1;
        5: sz = 9'($urandom_range(257, 511));
        default: sz = 9'($urandom_range(5, 16));
      endcase
      rxv = (p == 3) ? 1'($urandom_range(0, 1)) : (p == 0 || p == 2 || p == 5);
      drain();
      write_reg(REG_RECEIVE, {8'd0, rxv});
      write_reg(REG_QUEUE_SIZE, sz);
      calm = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 30) hold_request = 1'b1;
        send_item(random_item(), 1'b0, '0);
      end
      calm = 1'b0;
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side: stall at random, check every transaction
  initial begin
    vqdm_result_t got;
    vqdm_result_t want;
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_ready) begin
        got = vqdm_result_t'({status, desc_index, desc_length, desc_writable, avail_slot,
                              avail_index_out, used_slot, delivered_len, pending,
                              free_count_out});
        if (predicted_results.size() == 0) begin
          $error("result transaction with nothing expected");
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.desc_index !== want.desc_index) begin
            $error("desc_index: expected %0d, got %0d", want.desc_index, got.desc_index);
            mismatches++;
          end
          if (got.desc_length !== want.desc_length) begin
            $error("desc_length: expected %0d, got %0d", want.desc_length, got.desc_length);
            mismatches++;
          end
          if (got.desc_writable !== want.desc_writable) begin
            $error("desc_writable: expected %0d, got %0d", want.desc_writable,
                   got.desc_writable);
            mismatches++;
          end
          if (got.avail_slot !== want.avail_slot) begin
            $error("avail_slot: expected %0d, got %0d", want.avail_slot, got.avail_slot);
            mismatches++;
          end
          if (got.avail_index_out !== want.avail_index_out) begin
            $error("avail_index_out: expected %0d, got %0d", want.avail_index_out,
                   got.avail_index_out);
            mismatches++;
          end
          if (got.used_slot !== want.used_slot) begin
            $error("used_slot: expected %0d, got %0d", want.used_slot, got.used_slot);
            mismatches++;
          end
          if (got.delivered_len !== want.delivered_len) begin
            $error("delivered_len: expected %0d, got %0d", want.delivered_len,
                   got.delivered_len);
            mismatches++;
          end
          if (got.pending !== want.pending) begin
            $error("pending: expected %0d, got %0d", want.pending, got.pending);
            mismatches++;
          end
          if (got.free_count_out !== want.free_count_out) begin
            $error("free_count_out: expected %0d, got %0d", want.free_count_out,
                   got.free_count_out);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 7);
      end
    end
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule
